### rtl/hsr_pkg.sv
// ----------------------------------------------------------------------------
// hsr_pkg
// Shared types and constants for the two-wire humidity sensor reader.
// ----------------------------------------------------------------------------
`default_nettype none

package hsr_pkg;

  localparam int unsigned TIMEOUT_W  = 24;
  localparam int unsigned RESULT_W   = 16;
  localparam int unsigned S_TDATA_W  = 16;
  localparam int unsigned M_TDATA_W  = 24;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd1800;

  // Input kinds carried on the slave tuser bit
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_TS1      = 5'd1,
    PH_TS2      = 5'd2,
    PH_TS3      = 5'd3,
    PH_TS4      = 5'd4,
    PH_TS5      = 5'd5,
    PH_CMD_HI   = 5'd6,
    PH_CMD_LO   = 5'd7,
    PH_ACK_HI   = 5'd8,
    PH_ACK_LO   = 5'd9,
    PH_WAIT     = 5'd10,
    PH_RD_HI    = 5'd11,
    PH_RD_LO    = 5'd12,
    PH_MACK_SET = 5'd13,
    PH_MACK_HI  = 5'd14,
    PH_MACK_LO  = 5'd15,
    PH_CRC_HI   = 5'd16,
    PH_CRC_LO   = 5'd17
  } phase_t;

  // Levels of the two sensor lines as driven by the master
  typedef struct packed {
    logic en;
    logic dat;
    logic clk;
  } pins_t;

  localparam pins_t PINS_RELEASED = '{en: 1'b0, dat: 1'b0, clk: 1'b0};

  // Bit counter values that end the first byte and the whole word
  localparam logic [3:0] BIT_BYTE_END = 4'd7;
  localparam logic [3:0] BIT_WORD_END = 4'd15;

endpackage : hsr_pkg

`default_nettype wire

### rtl/humidity_sensor_two_wire_reader_unit.sv
// ----------------------------------------------------------------------------
// humidity_sensor_two_wire_reader_unit
// Bit-level master for a two-wire humidity / temperature sensor.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one item per transfer. tuser = 1 starts a
//   measurement with the command byte in tdata[7:0]; tuser = 0 is one pin
//   tick, with the sampled sensor data line in tdata[8]. Every accepted item
//   yields exactly one result on the master stream: the clock and data pin
//   levels to drive, busy, done, the timeout flag and, on the done tick, the
//   raw 16-bit word.
//   One item is taken every cycle while the receiver keeps up; every
//   sequencer register updates together on each accepted item.
//   The result register is refilled while it is being taken, so a receiver
//   that holds tready high sees no bubbles. When the receiver stalls, the
//   result is held and s_tready falls until it is taken.
//   Reset returns to idle with the clock line low, data released, the
//   timeout flag clear and the wait timeout at 1800 ticks. The timeout is
//   written through cfg_we / cfg_wdata; the user is to write it only while
//   no transaction is in progress; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module humidity_sensor_two_wire_reader_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [hsr_pkg::TIMEOUT_W-1:0]   cfg_wdata,
  input  wire logic                            s_tvalid,
  output      logic                            s_tready,
  // [7:0] command_byte, [8] data_line, [15:9] zero
  input  wire logic [hsr_pkg::S_TDATA_W-1:0]   s_tdata,
  // [0] cmd
  input  wire logic                            s_tuser,
  output      logic                            m_tvalid,
  input  wire logic                            m_tready,
  // [0] clock_out, [1] data_out, [2] data_enable, [3] busy_res,
  // [4] done_res, [5] timed_out, [21:6] raw_value, [23:22] zero
  output      logic [hsr_pkg::M_TDATA_W-1:0]   m_tdata
);

  import hsr_pkg::*;

  // Configuration
  logic [TIMEOUT_W-1:0] wait_timeout;

  // Sequencer state
  phase_t               phase, phase_next;
  logic [3:0]           bit_counter, bit_counter_next;
  logic [7:0]           command_shift, command_shift_next;
  logic [RESULT_W-1:0]  result_shift, result_shift_next;
  logic [TIMEOUT_W-1:0] wait_counter, wait_counter_next;
  pins_t                pins, pins_next;
  logic                 timeout_flag, timeout_flag_next;

  // Result fields computed for the current item
  logic                 busy_val, done_val;
  logic [RESULT_W-1:0]  raw_val;

  logic                 in_xfer;
  logic                 start;
  logic [7:0]           cbyte;
  logic                 dl;
  logic [TIMEOUT_W-1:0] limit;
  logic [TIMEOUT_W-1:0] wait_inc;
  logic                 cmd_bit;

  assign s_tready = !m_tvalid || m_tready;
  assign in_xfer  = s_tvalid && s_tready;
  assign start    = (s_tuser == CMD_START);
  assign cbyte    = s_tdata[7:0];
  assign dl       = s_tdata[8];
  assign limit    = (wait_timeout == '0) ? TIMEOUT_W'(1) : wait_timeout;
  assign wait_inc = wait_counter + TIMEOUT_W'(1);
  assign cmd_bit  = command_shift[~bit_counter[2:0]];

  // Next state
  always_comb begin
    phase_next         = phase;
    bit_counter_next   = bit_counter;
    command_shift_next = command_shift;
    result_shift_next  = result_shift;
    wait_counter_next  = wait_counter;
    timeout_flag_next  = timeout_flag;
    if (start) begin
      if (phase == PH_IDLE) begin
        command_shift_next = cbyte;
        result_shift_next  = '0;
        bit_counter_next   = '0;
        wait_counter_next  = '0;
        timeout_flag_next  = 1'b0;
        phase_next         = PH_TS1;
      end
    end else begin
      unique case (phase)
        PH_TS1:    phase_next = PH_TS2;
        PH_TS2:    phase_next = PH_TS3;
        PH_TS3:    phase_next = PH_TS4;
        PH_TS4:    phase_next = PH_TS5;
        PH_TS5: begin
          bit_counter_next = '0;
          phase_next       = PH_CMD_HI;
        end
        PH_CMD_HI: phase_next = PH_CMD_LO;
        PH_CMD_LO: begin
          if (bit_counter[2:0] == 3'd7) begin
            bit_counter_next = '0;
            phase_next       = PH_ACK_HI;
          end else begin
            bit_counter_next = bit_counter + 4'd1;
            phase_next       = PH_CMD_HI;
          end
        end
        PH_ACK_HI: phase_next = PH_ACK_LO;
        PH_ACK_LO: begin
          wait_counter_next = '0;
          phase_next        = PH_WAIT;
        end
        PH_WAIT: begin
          if (!dl) begin
            bit_counter_next = '0;
            phase_next       = PH_RD_HI;
          end else begin
            wait_counter_next = wait_inc;
            // give up waiting and read anyway
            if (wait_inc >= limit) begin
              timeout_flag_next = 1'b1;
              bit_counter_next  = '0;
              phase_next        = PH_RD_HI;
            end
          end
        end
        PH_RD_HI:  phase_next = PH_RD_LO;
        PH_RD_LO: begin
          result_shift_next = {result_shift[RESULT_W-2:0], dl};
          bit_counter_next  = bit_counter + 4'd1;
          if (bit_counter == BIT_BYTE_END) begin
            phase_next = PH_MACK_SET;
          end else if (bit_counter >= BIT_WORD_END) begin
            phase_next = PH_CRC_HI;
          end else begin
            phase_next = PH_RD_HI;
          end
        end
        PH_MACK_SET: phase_next = PH_MACK_HI;
        PH_MACK_HI:  phase_next = PH_MACK_LO;
        PH_MACK_LO:  phase_next = PH_RD_HI;
        PH_CRC_HI:   phase_next = PH_CRC_LO;
        PH_CRC_LO:   phase_next = PH_IDLE;
        default:     phase_next = PH_IDLE;
      endcase
    end
  end

  // Outputs: pin levels and result flags
  always_comb begin
    pins_next = pins;
    busy_val  = 1'b1;
    done_val  = 1'b0;
    raw_val   = '0;
    if (start) begin
      // hold pins on a start, whether taken or not
      busy_val = 1'b1;
    end else begin
      unique case (phase)
        PH_TS1:      pins_next = '{en: 1'b1, dat: 1'b1, clk: 1'b1};
        PH_TS2:      pins_next = '{en: 1'b1, dat: 1'b0, clk: 1'b1};
        PH_TS3:      pins_next = '{en: 1'b1, dat: 1'b0, clk: 1'b0};
        PH_TS4:      pins_next = '{en: 1'b1, dat: 1'b1, clk: 1'b1};
        PH_TS5:      pins_next = '{en: 1'b1, dat: 1'b1, clk: 1'b0};
        PH_CMD_HI:   pins_next = '{en: 1'b1, dat: cmd_bit, clk: 1'b1};
        PH_CMD_LO:   pins_next = '{en: 1'b1, dat: cmd_bit, clk: 1'b0};
        PH_ACK_HI:   pins_next = '{en: 1'b0, dat: 1'b0, clk: 1'b1};
        PH_ACK_LO:   pins_next = PINS_RELEASED;
        PH_WAIT:     pins_next = PINS_RELEASED;
        PH_RD_HI:    pins_next = '{en: 1'b0, dat: 1'b0, clk: 1'b1};
        PH_RD_LO:    pins_next = PINS_RELEASED;
        PH_MACK_SET: pins_next = '{en: 1'b1, dat: 1'b0, clk: 1'b0};
        PH_MACK_HI:  pins_next = '{en: 1'b1, dat: 1'b0, clk: 1'b1};
        PH_MACK_LO:  pins_next = '{en: 1'b1, dat: 1'b0, clk: 1'b0};
        PH_CRC_HI:   pins_next = '{en: 1'b1, dat: 1'b1, clk: 1'b1};
        PH_CRC_LO: begin
          pins_next = '{en: 1'b1, dat: 1'b1, clk: 1'b0};
          done_val  = 1'b1;
          raw_val   = result_shift;
        end
        default: begin
          pins_next = PINS_RELEASED;
          busy_val  = 1'b0;
        end
      endcase
      if (start == CMD_TICK && phase == PH_IDLE) begin
        busy_val = 1'b0;
      end
    end
    if (start && phase == PH_IDLE) begin
      busy_val = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_timeout <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      wait_timeout <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_counter   <= '0;
      command_shift <= '0;
      result_shift  <= '0;
      wait_counter  <= '0;
      pins          <= PINS_RELEASED;
      timeout_flag  <= 1'b0;
    end else if (in_xfer) begin
      phase         <= phase_next;
      bit_counter   <= bit_counter_next;
      command_shift <= command_shift_next;
      result_shift  <= result_shift_next;
      wait_counter  <= wait_counter_next;
      pins          <= pins_next;
      timeout_flag  <= timeout_flag_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_xfer) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      m_tdata <= {2'b00, raw_val, timeout_flag_next, done_val, busy_val,
                  pins_next.en, pins_next.en & pins_next.dat, pins_next.clk};
    end
  end

`ifndef SYNTHESIS
  a_crc_end_idle: assert property (@(posedge clk) disable iff (rst)
    in_xfer && !start && phase == PH_CRC_LO |=> phase == PH_IDLE)
    else $error("sequencer did not return to idle after the done tick");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    in_xfer && start && phase == PH_IDLE |=> phase == PH_TS1 && !timeout_flag)
    else $error("start from idle did not begin a fresh transaction");

  a_timeout_sets: assert property (@(posedge clk) disable iff (rst)
    in_xfer && !start && phase == PH_WAIT && dl && wait_inc >= limit
    |=> timeout_flag && phase == PH_RD_HI)
    else $error("wait timeout did not flag and move on to reading");

  a_cmd_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_CMD_HI || phase == PH_CMD_LO |-> !bit_counter[3])
    else $error("command bit counter out of range");

  a_done_pins: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4] |-> m_tdata[3] && m_tdata[2] && m_tdata[1] && !m_tdata[0])
    else $error("done result with wrong pin levels or busy low");

  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    in_xfer && start |=> m_tvalid && m_tdata[3])
    else $error("start item reported not busy");
`endif

endmodule : humidity_sensor_two_wire_reader_unit

`default_nettype wire
